// ===== design/srsm_pkg.sv =====
package srsm_pkg;

  // field widths
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W  = 21;
  localparam int unsigned END_W  = ADDR_W + 1;
  localparam int unsigned BLK_W  = 4;
  localparam int unsigned MASK_W = 32;
  localparam int unsigned SEC_W  = 4;

  // section geometry
  localparam int unsigned SMALL_SECTION_BYTES      = 4096;
  localparam int unsigned SMALL_BLOCKS             = 8;
  localparam int unsigned SECTIONS_PER_SMALL_BLOCK = 2;
  localparam int unsigned LARGE_SECTION_BYTES      = 32768;
  localparam int unsigned SECTIONS_PER_LARGE_BLOCK = 16;
  localparam int unsigned SMALL_REGION_BYTES =
    SMALL_BLOCKS * SECTIONS_PER_SMALL_BLOCK * SMALL_SECTION_BYTES;

  localparam int unsigned SSB_LOG2  = $clog2(SMALL_SECTION_BYTES);
  localparam int unsigned LSB_LOG2  = $clog2(LARGE_SECTION_BYTES);
  localparam int unsigned SPSB_LOG2 = $clog2(SECTIONS_PER_SMALL_BLOCK);
  localparam int unsigned SPLB_LOG2 = $clog2(SECTIONS_PER_LARGE_BLOCK);

  localparam int unsigned RETENTION_POS = 16;
  localparam int unsigned MAX_RESULTS   = 46;
  localparam int unsigned CNT_W         = $clog2(MAX_RESULTS);

  // configuration register map
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRAM_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRAM_SIZE = 1'b1;

  localparam logic [ADDR_W-1:0] SRAM_BASE_RST = 32'h2000_0000;
  localparam logic [LEN_W-1:0]  SRAM_SIZE_RST = 21'h04_0000;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [END_W-1:0]  limit;        // base + size, no wrap
    logic [END_W-1:0]  large_begin;  // base + small region bytes
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start_addr;
    logic [END_W-1:0]  end_addr;
    logic              set_retain;
    logic              range_error;
  } desc_t;

  typedef struct packed {
    logic [BLK_W-1:0]  block;
    logic [MASK_W-1:0] ret_mask;
    logic              set_retain_res;
    logic              range_error;
    logic              last;
  } res_t;

endpackage

// ===== design/srsm_front.sv =====
module srsm_front (
  input  logic                        push_i,
  input  logic [srsm_pkg::ADDR_W-1:0] start_addr_i,
  input  logic [srsm_pkg::LEN_W-1:0]  length_i,
  input  logic                        set_retain_i,
  input  srsm_pkg::cfg_t              cfg_i,
  input  logic                        q_full_i,
  output logic                        full_o,
  output logic                        q_push_o,
  output srsm_pkg::desc_t             q_desc_o
);
  import srsm_pkg::*;

  logic [END_W-1:0] end_addr;
  logic             reject;

  // exact end address, 33 bits so nothing wraps
  assign end_addr = {1'b0, start_addr_i} + END_W'(length_i);

  assign reject = (length_i == '0) || (start_addr_i < cfg_i.base) ||
                  (end_addr > cfg_i.limit);

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

  always_comb begin
    q_desc_o.start_addr  = start_addr_i;
    q_desc_o.end_addr    = end_addr;
    q_desc_o.set_retain  = set_retain_i;
    q_desc_o.range_error = reject;
  end

endmodule

// ===== design/srsm_queue.sv =====
module srsm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  srsm_pkg::desc_t desc_i,
  input  logic            pop_i,
  output srsm_pkg::desc_t desc_o,
  output logic            full_o,
  output logic            empty_o
);
  import srsm_pkg::*;

  desc_t                    mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] count_q, count_d;
  logic                     do_push, do_pop;

  assign full_o  = (count_q == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign desc_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");

endmodule

// ===== design/srsm_back.sv =====
module srsm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  srsm_pkg::cfg_t  cfg_i,
  input  srsm_pkg::desc_t q_desc_i,
  input  logic            q_empty_i,
  output logic            q_pop_o,
  output srsm_pkg::res_t  res_o,
  output logic            empty_o,
  input  logic            pop_i
);
  import srsm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e           state_q, state_d;
  logic [END_W-1:0] cursor_q, cursor_d;
  logic [END_W-1:0] end_q, end_d;
  logic             mode_q, mode_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;

  logic             slot_free;
  logic             hi_region;
  logic [END_W-1:0] region_base;
  logic [END_W-1:0] diff;
  logic [END_W-1:0] sec_idx;
  logic [END_W-1:0] blk_sum;
  logic [END_W-1:0] sec_in;
  logic [5:0]       shamt;
  logic [END_W-1:0] cur_floor;
  logic [END_W-1:0] next_cursor;
  logic             fin;

  // section lookup for the current cursor
  assign hi_region   = (cursor_q >= cfg_i.large_begin);
  assign region_base = hi_region ? cfg_i.large_begin : {1'b0, cfg_i.base};
  assign diff        = cursor_q - region_base;
  assign sec_idx     = hi_region ? (diff >> LSB_LOG2) : (diff >> SSB_LOG2);
  assign blk_sum     = hi_region ?
                       (END_W'(SMALL_BLOCKS) + (sec_idx >> SPLB_LOG2)) :
                       (sec_idx >> SPSB_LOG2);
  assign sec_in      = hi_region ? (sec_idx & END_W'(SECTIONS_PER_LARGE_BLOCK - 1)) :
                                   (sec_idx & END_W'(SECTIONS_PER_SMALL_BLOCK - 1));
  assign shamt       = 6'(RETENTION_POS) + 6'(sec_in[SEC_W-1:0]);

  // step to the next section boundary, aligned from address zero
  assign cur_floor   = hi_region ? (cursor_q & ~END_W'(LARGE_SECTION_BYTES - 1)) :
                                   (cursor_q & ~END_W'(SMALL_SECTION_BYTES - 1));
  assign next_cursor = cur_floor + (hi_region ? END_W'(LARGE_SECTION_BYTES) :
                                                END_W'(SMALL_SECTION_BYTES));
  assign fin         = (next_cursor >= end_q) ||
                       (count_q == CNT_W'(MAX_RESULTS - 1));

  assign slot_free = !out_valid_q || pop_i;

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    end_d       = end_q;
    mode_d      = mode_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !pop_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (slot_free && !q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_desc_i.range_error) begin
            out_valid_d          = 1'b1;
            out_d.block          = '0;
            out_d.ret_mask       = '0;
            out_d.set_retain_res = q_desc_i.set_retain;
            out_d.range_error    = 1'b1;
            out_d.last           = 1'b1;
          end else begin
            cursor_d = {1'b0, q_desc_i.start_addr};
            end_d    = q_desc_i.end_addr;
            mode_d   = q_desc_i.set_retain;
            count_d  = '0;
            state_d  = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_d.block          = blk_sum[BLK_W-1:0];
          out_d.ret_mask       = MASK_W'(1) << shamt;
          out_d.set_retain_res = mode_q;
          out_d.range_error    = 1'b0;
          out_d.last           = fin;
          cursor_d             = next_cursor;
          count_d              = count_q + 1'b1;
          if (fin) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      end_q       <= '0;
      mode_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      end_q       <= end_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign res_o   = out_q;
  assign empty_o = !out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (count_q < CNT_W'(MAX_RESULTS)))
    else $error("section walk ran past the result limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.range_error) |->
      (out_q.last && (out_q.ret_mask == '0) && (out_q.block == '0)))
    else $error("rejected request word malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.range_error) |-> $onehot(out_q.ret_mask[MASK_W-1:RETENTION_POS]))
    else $error("retention mask not one-hot in the upper half");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> !q_pop_o)
    else $error("queue popped during a section walk");

endmodule

// ===== design/sram_retention_section_mapper_unit.sv =====
// sram retention section mapper: each pushed request (start address, length, set or clear)
// yields one result word per ram section that the byte range touches, giving the power
// block and a one-hot retention mask (bit 16 plus the section within the block); the
// low region holds 8 blocks of two 4 KiB sections from sram_base, above it come 32 KiB
// sections, 16 to a block, from block 8 upward, and section boundaries are aligned from
// address zero; a zero length or a range not wholly inside [sram_base, sram_base +
// sram_size) gives a single word with range_error and last set; at most 46 words are
// produced per request, the final one carrying last. the front checks a request in the
// cycle it is pushed and parks it in a two-entry queue; the back loads a request from the
// queue and then walks the sections, one result word per cycle into an output register
// while that register is free or being popped, and a rejected request gives its single
// word without a walk; the section walk in the back sets that rate, and new
// requests are still taken while the queue has room. configuration is written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i (index 0 sram_base, index 1 sram_size in bits 20:0)
// and must only change while the block is idle
module sram_retention_section_mapper_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration port
  input  logic                           cfg_we_i,
  input  logic [srsm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [srsm_pkg::ADDR_W-1:0]    cfg_wdata_i,
  // request side
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [srsm_pkg::ADDR_W-1:0]    start_addr_i,
  input  logic [srsm_pkg::LEN_W-1:0]     length_i,
  input  logic                           set_retain_i,
  // result side
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [srsm_pkg::BLK_W-1:0]     block_o,
  output logic [srsm_pkg::MASK_W-1:0]    section_mask_o,
  output logic                           set_retain_res_o,
  output logic                           range_error_o,
  output logic                           last_o
);
  import srsm_pkg::*;

  // configuration registers, with the derived bounds kept alongside
  logic [ADDR_W-1:0] base_q, base_d;
  logic [LEN_W-1:0]  size_q, size_d;
  logic [END_W-1:0]  limit_q, limit_d;
  logic [END_W-1:0]  large_q, large_d;
  cfg_t              cfg;

  // front to queue to back
  logic  q_push, q_pop, q_full, q_empty;
  desc_t q_in, q_out;
  res_t  res;

  always_comb begin
    base_d  = base_q;
    size_d  = size_q;
    limit_d = limit_q;
    large_d = large_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SRAM_BASE: begin
          base_d  = cfg_wdata_i;
          limit_d = {1'b0, cfg_wdata_i} + END_W'(size_q);
          large_d = {1'b0, cfg_wdata_i} + END_W'(SMALL_REGION_BYTES);
        end
        CFG_SRAM_SIZE: begin
          size_d  = cfg_wdata_i[LEN_W-1:0];
          limit_d = {1'b0, base_q} + END_W'(cfg_wdata_i[LEN_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= SRAM_BASE_RST;
      size_q  <= SRAM_SIZE_RST;
      limit_q <= {1'b0, SRAM_BASE_RST} + END_W'(SRAM_SIZE_RST);
      large_q <= {1'b0, SRAM_BASE_RST} + END_W'(SMALL_REGION_BYTES);
    end else begin
      base_q  <= base_d;
      size_q  <= size_d;
      limit_q <= limit_d;
      large_q <= large_d;
    end
  end

  always_comb begin
    cfg.base        = base_q;
    cfg.limit       = limit_q;
    cfg.large_begin = large_q;
  end

  // request check and classification
  srsm_front u_front (
    .push_i       (push_i),
    .start_addr_i (start_addr_i),
    .length_i     (length_i),
    .set_retain_i (set_retain_i),
    .cfg_i        (cfg),
    .q_full_i     (q_full),
    .full_o       (full_o),
    .q_push_o     (q_push),
    .q_desc_o     (q_in)
  );

  // decoupling queue
  srsm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (q_in),
    .pop_i   (q_pop),
    .desc_o  (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // section walk and result register
  srsm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_desc_i  (q_out),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .res_o     (res),
    .empty_o   (empty_o),
    .pop_i     (pop_i)
  );

  assign block_o          = res.block;
  assign section_mask_o   = res.ret_mask;
  assign set_retain_res_o = res.set_retain_res;
  assign range_error_o    = res.range_error;
  assign last_o           = res.last;

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srsm_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 2_000;

  // one pending request as the sender will push it
  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              mode;
  } request_t;

  // clock, reset and every block input start at known values
  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i    = CFG_SRAM_BASE;
  logic [ADDR_W-1:0]    cfg_wdata_i  = '0;
  logic                 push_i       = 1'b0;
  logic [ADDR_W-1:0]    start_addr_i = '0;
  logic [LEN_W-1:0]     length_i     = '0;
  logic                 set_retain_i = 1'b0;
  logic                 pop_i        = 1'b0;
  logic                 full_o;
  logic                 empty_o;
  logic [BLK_W-1:0]     block_o;
  logic [MASK_W-1:0]    section_mask_o;
  logic                 set_retain_res_o;
  logic                 range_error_o;
  logic                 last_o;

  // window the predictor works against, tracks the block's registers
  logic [ADDR_W-1:0] win_base = SRAM_BASE_RST;
  logic [LEN_W-1:0]  win_size = SRAM_SIZE_RST;

  request_t req_backlog[$];
  res_t     due_words[$];

  // idling percentages for the current phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned cycles     = 0;
  int          n_requests = 0;
  int          n_words    = 0;
  int          n_rejects  = 0;
  int          n_capped   = 0;
  int          n_windows  = 1;
  int          n_errors   = 0;

  sram_retention_section_mapper_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  // section walk for one accepted request, appends the words it must give
  function automatic void map_sections(input logic [ADDR_W-1:0] addr,
                                       input logic [LEN_W-1:0] len, input logic mode);
    logic [63:0] lo, lim, big, cur, fence, origin, ssz, per, sec, blk;
    res_t        w;
    int          n;
    lo    = 64'(win_base);
    lim   = lo + 64'(win_size);
    big   = lo + 64'(SMALL_REGION_BYTES);
    cur   = 64'(addr);
    fence = cur + 64'(len);
    n     = 0;
    w.set_retain_res = mode;
    w.range_error    = 1'b0;
    n_requests++;
    // empty object, or any byte outside the window, no wrap allowed
    if (len == '0 || cur < lo || fence > lim) begin
      w.block       = '0;
      w.ret_mask    = '0;
      w.range_error = 1'b1;
      w.last        = 1'b1;
      due_words.push_back(w);
      n_rejects++;
      return;
    end
    do begin
      if (cur >= big) begin
        origin = big;
        ssz    = 64'(LARGE_SECTION_BYTES);
        per    = 64'(SECTIONS_PER_LARGE_BLOCK);
        blk    = 64'(SMALL_BLOCKS);
      end else begin
        origin = lo;
        ssz    = 64'(SMALL_SECTION_BYTES);
        per    = 64'(SECTIONS_PER_SMALL_BLOCK);
        blk    = 64'd0;
      end
      // index counted from the region start, step aligned from address zero
      sec = (cur - origin) / ssz;
      blk = blk + sec / per;
      w.block    = blk[BLK_W-1:0];
      w.ret_mask = MASK_W'(64'd1 << (sec % per + RETENTION_POS));
      cur = cur + ssz - (cur % ssz);
      n++;
      w.last = (cur >= fence) || (n >= int'(MAX_RESULTS));
      due_words.push_back(w);
    end while (!w.last);
    if (cur < fence) n_capped++;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    end
  endfunction

  // driver: pulls from the backlog, predicts on every accepted request
  always @(posedge clk_i) begin
    request_t nxt;
    if (!rst_ni) begin
      push_i <= 1'b0;
    end else begin
      if (push_i && !full_o) map_sections(start_addr_i, length_i, set_retain_i);
      // slot is free when nothing is offered or the offer was just taken
      if (!push_i || !full_o) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = req_backlog.pop_front();
          push_i       <= 1'b1;
          start_addr_i <= nxt.addr;
          length_i     <= nxt.len;
          set_retain_i <= nxt.mode;
        end else begin
          push_i <= 1'b0;
        end
      end
    end
  end

  // monitor: every popped word against the oldest prediction
  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else begin
      if (pop_i && !empty_o) begin
        n_words++;
        if (due_words.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected word expected none got block %0d mask 0x%0h err %0b last %0b",
                   $time, block_o, section_mask_o, range_error_o, last_o);
        end else begin
          want = due_words.pop_front();
          check_field("block", 32'(want.block), 32'(block_o));
          check_field("retention mask", want.ret_mask, section_mask_o);
          check_field("set_retain_res", 32'(want.set_retain_res), 32'(set_retain_res_o));
          check_field("range_error", 32'(want.range_error), 32'(range_error_o));
          check_field("last", 32'(want.last), 32'(last_o));
        end
      end
      pop_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: run stopped after %0d cycles, %0d words still due",
               $time, cycles, due_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_item(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len,
                            input logic mode);
    request_t r;
    r.addr = addr;
    r.len  = len;
    r.mode = mode;
    req_backlog.push_back(r);
  endtask

  // sender holds off until every predicted word has been popped
  task automatic settle();
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || push_i || due_words.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // only called with the block idle
  task automatic program_window(input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] size);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SRAM_BASE;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SRAM_SIZE;
    cfg_wdata_i <= ADDR_W'(size);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    win_base = base;
    win_size = size;
    n_windows++;
  endtask

  // mostly in-window objects of modest size, some up to the rest of the window, the rest noise
  task automatic add_random(input int count);
    request_t    r;
    logic [63:0] off, room, cap;
    int unsigned pick;
    repeat (count) begin
      pick   = $urandom_range(99);
      r.mode = 1'($urandom_range(1));
      off    = 64'($urandom_range(32'(win_size) - 1, 0));
      room   = 64'(win_size) - off;
      r.addr = win_base + ADDR_W'(off);
      if (pick < 85) begin
        pick = $urandom_range(99);
        cap  = (pick < 70) ? 64'd8192 : (pick < 90) ? 64'd65536 : 64'h10_0000;
        if (cap > room) cap = room;
        r.len = LEN_W'($urandom_range(32'(cap), 1));
      end else begin
        case (pick % 5)
          0: r.len = '0;
          1: begin
            r.addr = win_base - 32'd1 - 32'($urandom_range(255));
            r.len  = LEN_W'($urandom_range(4096, 1));
          end
          2: r.len = LEN_W'(room + 1);
          3: begin
            r.addr = $urandom;
            r.len  = LEN_W'($urandom);
          end
          default: begin
            r.addr = $urandom;
            r.len  = LEN_W'($urandom_range(32'h10_0000, 1));
          end
        endcase
      end
      req_backlog.push_back(r);
    end
  endtask

  initial begin
    int          send_pct[4];
    int          recv_pct[4];
    logic [31:0] seg_base;
    logic [20:0] seg_size;
    int          waited;
    send_pct = '{0, 75, 0, 33};
    recv_pct = '{0, 0, 75, 33};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed, reset window 0x2000_0000 + 256 KiB
    queue_item(32'h2000_0000, 21'd0, 1'b1);           // empty object
    queue_item(32'h1FFF_FFFF, 21'd1, 1'b0);           // one byte below the window
    queue_item(32'h2000_0000, 21'h04_0000, 1'b1);     // whole window
    queue_item(32'h2000_0000, 21'h04_0001, 1'b0);     // one byte past the top
    queue_item(32'h2003_FFFF, 21'd1, 1'b1);           // top byte, large region
    queue_item(32'h2000_0000, 21'd1, 1'b0);           // first byte, clear
    queue_item(32'h2000_0FFF, 21'd2, 1'b1);           // straddles two small sections
    queue_item(32'h2000_FFFF, 21'd2, 1'b0);           // straddles small into large
    queue_item(32'hFFFF_FFFF, 21'h1F_FFFF, 1'b1);     // all ones, sum past 32 bits
    queue_item(32'h0000_0000, 21'd1, 1'b0);           // address zero
    settle();

    // unaligned base, biggest window: a whole-window object overruns the cap
    program_window(32'h2000_0800, 21'h10_0000);
    queue_item(32'h2000_0800, 21'h10_0000, 1'b1);
    queue_item(32'h2000_0FFF, 21'h00_0801, 1'b0);
    settle();

    // empty window rejects everything
    program_window(32'h0000_0000, 21'd0);
    queue_item(32'h0000_0000, 21'd1, 1'b1);
    queue_item(32'h0000_0000, 21'd0, 1'b0);
    settle();

    // single byte window at the very top of the address space
    program_window(32'hFFFF_FFFF, 21'd1);
    queue_item(32'hFFFF_FFFF, 21'd1, 1'b1);
    queue_item(32'hFFFF_FFFF, 21'd2, 1'b0);
    settle();

    // aligned 1 MiB from zero fills the cap exactly
    program_window(32'h0000_0000, 21'h10_0000);
    queue_item(32'h0000_0000, 21'h10_0000, 1'b0);
    queue_item(32'h000F_FFFF, 21'd1, 1'b1);
    settle();

    // random segments, each with its own window and idling pattern
    for (int s = 0; s < 8; s++) begin
      case (s)
        0: begin seg_base = 32'h2000_0000; seg_size = 21'h04_0000; end
        1: begin seg_base = 32'h2000_0800; seg_size = 21'h10_0000; end
        2: begin seg_base = 32'h0000_0000; seg_size = 21'h10_0000; end
        3: begin seg_base = 32'hFFF0_0000; seg_size = 21'h10_0000; end
        4: begin seg_base = 32'hFFFF_0000; seg_size = 21'h10_0000; end
        5: begin seg_base = $urandom; seg_size = 21'($urandom_range(32'h10_0000, 1)); end
        6: begin seg_base = 32'h0000_0000; seg_size = 21'd1; end
        default: begin
          seg_base = $urandom | 32'd1;
          seg_size = 21'($urandom_range(32'h10_0000, 1));
        end
      endcase
      program_window(seg_base, seg_size);
      send_idle_pct  = send_pct[s % 4];
      recv_stall_pct = recv_pct[s % 4];
      add_random(30);
      // sender pauses mid segment until the block has drained
      settle();
      add_random(29);
      settle();
    end

    // final drain with a bounded wait
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || push_i);
    waited = 0;
    while (due_words.size() != 0 && waited < DRAIN_CYCLES) begin
      @(negedge clk_i);
      waited++;
    end
    if (due_words.size() != 0) begin
      n_errors += due_words.size();
      $display("%0t: %0d predicted words never arrived", $time, due_words.size());
    end
    repeat (100) @(negedge clk_i);

    $display("run: %0d requests over %0d window settings, %0d words popped",
             n_requests, n_windows, n_words);
    $display("run: %0d rejected, %0d cut short at the word cap, %0d errors",
             n_rejects, n_capped, n_errors);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/srsm_pkg.sv
design/srsm_front.sv
design/srsm_queue.sv
design/srsm_back.sv
design/sram_retention_section_mapper_unit.sv
bench/tb_top.sv
